// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, ignored during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, ignored during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked through reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/bbd_pkg.sv =====
// shared types, constants and helpers for the bayer demosaic block
package bbd_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   localparam int SAMPLE_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAYER_ORDER  = 2'd2;

   // where the output pixel sits in the frame
   typedef struct packed {
      logic vl;     // left neighbour inside the frame
      logic vr;     // right neighbour inside the frame
      logic vu;     // upper neighbour inside the frame
      logic vd;     // lower neighbour inside the frame
      logic px;     // column parity
      logic py;     // row parity
      logic last;   // last pixel of the frame
   } pos_type;

   // zero reads as one, anything above the limit saturates
   function automatic int clamp_dim(input logic [CSR_DATA_W-1:0] v, input int maxv);
      int r;
      r = int'(v);
      if (r == 0) begin
         r = 1;
      end else if (r > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

// ===== sv/bbd_interp.sv =====
// bilinear colour reconstruction of one pixel from its 3x3 neighbourhood
module bbd_interp (
   input  logic [8:0][bbd_pkg::SAMPLE_W-1:0] win,   // row-major, up-left first
   input  bbd_pkg::pos_type                  pos,
   input  logic [1:0]                        order,
   output logic [bbd_pkg::SAMPLE_W-1:0]      red,
   output logic [bbd_pkg::SAMPLE_W-1:0]      green,
   output logic [bbd_pkg::SAMPLE_W-1:0]      blue
);

   localparam logic [19:0] RECIP3     = 20'd683;
   localparam int          RECIP3_SHR = 11;

   // truncated mean of up to four samples, divide by three via reciprocal
   function automatic logic [7:0] mean(input logic [9:0] sum, input logic [2:0] cnt);
      logic [19:0] prod;
      logic [7:0]  r;
      prod = 20'(sum) * RECIP3;
      case (cnt)
         3'd1:    r = sum[7:0];
         3'd2:    r = sum[8:1];
         3'd3:    r = prod[RECIP3_SHR+7:RECIP3_SHR];
         3'd4:    r = sum[9:2];
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   logic [8:0] hs, vs;
   logic [9:0] ds, hvs;
   logic [2:0] hc, vc, dc, hvc;
   logic [7:0] ctr, m_h, m_v, m_d, m_hv;
   logic       site_r, site_b;

   always_comb begin
      hs  = (pos.vl ? 9'(win[3]) : 9'd0) + (pos.vr ? 9'(win[5]) : 9'd0);
      vs  = (pos.vu ? 9'(win[1]) : 9'd0) + (pos.vd ? 9'(win[7]) : 9'd0);
      hc  = 3'(pos.vl) + 3'(pos.vr);
      vc  = 3'(pos.vu) + 3'(pos.vd);
      ds  = ((pos.vl && pos.vu) ? 10'(win[0]) : 10'd0)
          + ((pos.vr && pos.vu) ? 10'(win[2]) : 10'd0)
          + ((pos.vl && pos.vd) ? 10'(win[6]) : 10'd0)
          + ((pos.vr && pos.vd) ? 10'(win[8]) : 10'd0);
      dc  = 3'(pos.vl && pos.vu) + 3'(pos.vr && pos.vu)
          + 3'(pos.vl && pos.vd) + 3'(pos.vr && pos.vd);
      hvs = 10'(hs) + 10'(vs);
      hvc = hc + vc;

      ctr  = win[4];
      m_h  = mean(10'(hs), hc);
      m_v  = mean(10'(vs), vc);
      m_d  = mean(ds, dc);
      m_hv = mean(hvs, hvc);

      site_r = (pos.px == order[0]) && (pos.py == order[1]);
      site_b = (pos.px != order[0]) && (pos.py != order[1]);

      if (site_r) begin
         red   = ctr;
         green = m_hv;
         blue  = m_d;
      end else if (site_b) begin
         red   = m_d;
         green = m_hv;
         blue  = ctr;
      end else if (pos.py == order[1]) begin
         // green on a red row
         red   = m_h;
         green = ctr;
         blue  = m_v;
      end else begin
         // green on a blue row
         red   = m_v;
         green = ctr;
         blue  = m_h;
      end
   end

endmodule

// ===== sv/bayer_bilinear_demosaic.sv =====
// bilinear bayer demosaic: raw 8-bit samples in, full rgb pixels out
//
// Raw samples enter in raster order; while no result waits on rsp_tready,
// one transaction enters per clock and the block sustains one pixel per cycle.
// Each rgb pixel leaves frame_width+1 input transactions after its own sample,
// so the source appends frame_width+1 flush transactions (tuser high) after
// each frame to push the tail out; a flush counts as a zero sample. Internally
// the accepting edge reads the line memory into a register; when the read
// stage moves on, it shifts the 3x3 window and computes the colours into the
// output register, from which the result shows on rsp_. A result held by
// rsp_tready low stalls the read stage, and with it req_tready, until it is
// taken. The line memory (one port written, one read, registered read data)
// holds the two previous rows side by side and is rewritten at the same
// address it was read; back-to-back hits on one address (width of one) are
// served by forwarding. The memory needs no clearing: entries never written
// are only read outside the frame. Writing frame_width or frame_height
// restarts the frame; bayer_order takes effect at once. Configure only while
// idle.
module bayer_bilinear_demosaic #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bbd_pkg::SAMPLE_W-1:0]     req_tdata,   // sample
   input  logic                             req_tuser,   // cmd: flush when high

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [3*bbd_pkg::SAMPLE_W-1:0]   rsp_tdata,   // blue, green, red from the top byte down
   output logic                             rsp_tlast,   // frame_end

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int SW = bbd_pkg::SAMPLE_W;
   localparam int CW = $clog2(MAX_WIDTH);       // column index
   localparam int WW = $clog2(MAX_WIDTH + 1);   // frame width
   localparam int XW = CW + 1;                  // column plus one
   localparam int RW = $clog2(MAX_HEIGHT);      // row index
   localparam int HW = $clog2(MAX_HEIGHT + 1);  // frame height
   localparam int YW = RW + 1;                  // row plus one

   // configuration
   logic [WW-1:0] width_ff,  width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [1:0]    order_ff,  order_in;
   logic          restart;

   // input and output position counters
   logic [CW-1:0] in_col_ff,  in_col_in;
   logic [1:0]    in_row_ff,  in_row_in;   // saturates at two, enough for priming
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;

   // line memory: far row in the upper byte, near row in the lower
   logic [2*SW-1:0] line_mem [MAX_WIDTH];
   logic [2*SW-1:0] mem_rd_ff;

   // read stage
   logic                  s1_valid_ff,  s1_valid_in;
   logic [SW-1:0]         s1_sample_ff;
   logic [CW-1:0]         s1_addr_ff;
   logic                  s1_primed_ff;
   bbd_pkg::pos_type      s1_pos_ff;
   logic                  s1_fwd_ff;
   logic [SW-1:0]         s1_fwd_near_ff, s1_fwd_far_ff;

   // window: left and centre columns, top to bottom
   logic [SW-1:0] col_c_ff [3];
   logic [SW-1:0] col_r_ff [3];

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3*SW-1:0]      rsp_data_ff;
   logic                 rsp_last_ff;

   logic                 req_fire, adv_out, s1_go, s1_emit, primed, col_wrap;
   logic [XW-1:0]        in_col_next, out_col_next;
   logic [YW-1:0]        out_row_next;
   logic [SW-1:0]        sample_in, near_eff, far_eff;
   bbd_pkg::pos_type     pos_in;
   logic [8:0][SW-1:0]   win;
   logic [SW-1:0]        red, green, blue;

   assign csr_ready = 1'b1;

   // pipeline flow: the read stage stalls only behind an unread result
   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_primed_ff || adv_out);
   assign s1_emit    = s1_go && s1_primed_ff;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   assign sample_in = req_tuser ? '0 : req_tdata;

   // position bookkeeping for the arriving transaction
   always_comb begin
      in_col_next  = XW'(in_col_ff) + XW'(1);
      col_wrap     = in_col_next >= XW'(width_ff);
      primed       = (in_row_ff == 2'd2) || ((in_row_ff == 2'd1) && (in_col_ff != '0));
      out_col_next = XW'(out_col_ff) + XW'(1);
      out_row_next = YW'(out_row_ff) + YW'(1);

      pos_in.vl   = out_col_ff != '0;
      pos_in.vr   = out_col_next < XW'(width_ff);
      pos_in.vu   = out_row_ff != '0;
      pos_in.vd   = out_row_next < YW'(height_ff);
      pos_in.px   = out_col_ff[0];
      pos_in.py   = out_row_ff[0];
      pos_in.last = !pos_in.vr && !pos_in.vd;
   end

   // configuration writes and counter updates
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      order_in  = order_ff;
      restart   = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bbd_pkg::CSR_FRAME_WIDTH: begin
               width_in = WW'(bbd_pkg::clamp_dim(csr_data, MAX_WIDTH));
               restart  = 1'b1;
            end
            bbd_pkg::CSR_FRAME_HEIGHT: begin
               height_in = HW'(bbd_pkg::clamp_dim(csr_data, MAX_HEIGHT));
               restart   = 1'b1;
            end
            bbd_pkg::CSR_BAYER_ORDER: begin
               order_in = csr_data[1:0];
            end
            default: begin
            end
         endcase
      end

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (req_fire) begin
         if (col_wrap) begin
            in_col_in = '0;
            if (in_row_ff != 2'd2) begin
               in_row_in = in_row_ff + 2'd1;
            end
         end else begin
            in_col_in = CW'(in_col_next);
         end
         if (primed) begin
            if (pos_in.last) begin
               // frame complete: every position starts over
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!pos_in.vr) begin
               out_col_in = '0;
               out_row_in = RW'(out_row_next);
            end else begin
               out_col_in = CW'(out_col_next);
            end
         end
      end
   end

   // forwarding covers a read of the entry the read stage writes this cycle
   assign near_eff = s1_fwd_ff ? s1_fwd_near_ff : mem_rd_ff[SW-1:0];
   assign far_eff  = s1_fwd_ff ? s1_fwd_far_ff  : mem_rd_ff[2*SW-1:SW];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // window after this pixel's shift, as the interpolator sees it
   assign win[0] = col_c_ff[0];
   assign win[1] = col_r_ff[0];
   assign win[2] = far_eff;
   assign win[3] = col_c_ff[1];
   assign win[4] = col_r_ff[1];
   assign win[5] = near_eff;
   assign win[6] = col_c_ff[2];
   assign win[7] = col_r_ff[2];
   assign win[8] = s1_sample_ff;

   bbd_interp u_interp (
      .win   (win),
      .pos   (s1_pos_ff),
      .order (order_ff),
      .red   (red),
      .green (green),
      .blue  (blue)
   );

   // line memory: read on accept, write back when the read stage moves on
   always_ff @(posedge clock) begin
      if (s1_go) begin
         line_mem[s1_addr_ff] <= {near_eff, s1_sample_ff};
      end
      if (req_fire) begin
         mem_rd_ff <= line_mem[in_col_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(bbd_pkg::clamp_dim(bbd_pkg::CSR_DATA_W'(bbd_pkg::WIDTH_RESET),
                         MAX_WIDTH));
         height_ff    <= HW'(bbd_pkg::clamp_dim(bbd_pkg::CSR_DATA_W'(bbd_pkg::HEIGHT_RESET),
                         MAX_HEIGHT));
         order_ff     <= '0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            col_c_ff[i] <= '0;
            col_r_ff[i] <= '0;
         end
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         order_ff     <= order_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            for (int i = 0; i < 3; i++) begin
               col_c_ff[i] <= col_r_ff[i];
            end
            col_r_ff[0] <= far_eff;
            col_r_ff[1] <= near_eff;
            col_r_ff[2] <= s1_sample_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff   <= sample_in;
         s1_addr_ff     <= in_col_ff;
         s1_primed_ff   <= primed;
         s1_pos_ff      <= pos_in;
         s1_fwd_ff      <= s1_go && (s1_addr_ff == in_col_ff);
         s1_fwd_near_ff <= s1_sample_ff;
         s1_fwd_far_ff  <= near_eff;
      end
      if (s1_emit) begin
         rsp_data_ff <= {blue, green, red};
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/bbd_checker.sv =====
// port-level checks for the bayer demosaic block, bound to the top level
`include "assert_macros.svh"

module bbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // with the output register empty nothing blocks the input
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // a fresh result always comes from a transaction accepted into the read stage that passed on without a stall
   `ASSERT_SAME(a_rsp_follows_req, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

   // reset empties the output
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
